// File: hdl/rfps_pkg.sv
// ----------------------------------------------------------------------------
// rfps_pkg
// Shared types and default constants for the ring buffer with peek and skip.
// ----------------------------------------------------------------------------
package rfps_pkg;

  localparam int DEPTH_DEFAULT      = 1024;
  localparam int DATA_WIDTH_DEFAULT = 8;

  typedef enum logic [1:0] {
    OP_PUT  = 2'd0,
    OP_TAKE = 2'd1,
    OP_PEEK = 2'd2,
    OP_SKIP = 2'd3
  } op_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;  // an input word is accepted this cycle
    logic load;   // move the staged result into the output register
  } cmd_t;

endpackage

// File: hdl/ring_fifo_peek_skip.sv
// ----------------------------------------------------------------------------
// ring_fifo_peek_skip
// Circular element buffer with put, take, peek at offset and skip operations.
// ----------------------------------------------------------------------------
// Each input word carries one operation; each accepted word yields exactly one
// result word with the data read, a success flag, the fill level after the
// operation and a copy of the end-of-transfer mark. Both channels use a
// valid/ready handshake.
// An accepted word is not followed by another until its result has moved
// into the output register. The element memory has a registered read port:
// the word's data is first registered in mem_q, then loaded into the
// output register.
// The output register decouples the two sides: the next input word is
// accepted while the previous result still waits for the receiver. While the
// receiver stalls with a result pending and another staged behind it, input
// ready stays low.
// Reset clears the slots and the fill level; the buffer is empty and usable
// in the first cycle after reset. Memory contents are not cleared, since an
// entry is never read before it is written.
// ----------------------------------------------------------------------------
module ring_fifo_peek_skip #(
  parameter int DEPTH      = rfps_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rfps_pkg::DATA_WIDTH_DEFAULT,
  parameter int FW         = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [1:0]            operation,
  input  logic [DATA_WIDTH-1:0] write_data,
  input  logic [FW-1:0]         offset,
  input  logic                  end_of_transfer,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic                  success,
  output logic [FW-1:0]         fill_level,
  output logic                  last
);

  rfps_pkg::cmd_t cmd;

  rfps_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rfps_datapath #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH),
    .AW         ($clog2(DEPTH)),
    .FW         (FW)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .operation       (operation),
    .write_data      (write_data),
    .offset          (offset),
    .end_of_transfer (end_of_transfer),
    .read_data       (read_data),
    .success         (success),
    .fill_level      (fill_level),
    .last            (last)
  );

endmodule

// File: hdl/rfps_datapath.sv
// ----------------------------------------------------------------------------
// rfps_datapath
// Element memory, read and write slots, fill level and the result registers.
// ----------------------------------------------------------------------------
module rfps_datapath #(
  parameter int DEPTH      = rfps_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rfps_pkg::DATA_WIDTH_DEFAULT,
  parameter int AW         = $clog2(DEPTH),
  parameter int FW         = $clog2(DEPTH + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rfps_pkg::cmd_t        cmd,
  input  logic [1:0]            operation,
  input  logic [DATA_WIDTH-1:0] write_data,
  input  logic [FW-1:0]         offset,
  input  logic                  end_of_transfer,
  output logic [DATA_WIDTH-1:0] read_data,
  output logic                  success,
  output logic [FW-1:0]         fill_level,
  output logic                  last
);

  localparam int SW = FW + 1;

  logic [DATA_WIDTH-1:0] mem [DEPTH];
  logic [DATA_WIDTH-1:0] mem_q;

  logic [AW-1:0] wr_slot;
  logic [AW-1:0] rd_slot;
  logic [FW-1:0] fill;
  logic [AW-1:0] wr_slot_next;
  logic [AW-1:0] rd_slot_next;
  logic [FW-1:0] fill_next;

  logic ok_q;
  logic rd_sel;
  logic eot_q;

  rfps_pkg::op_t op;
  logic          ok;
  logic [SW-1:0] sum;
  logic [AW-1:0] sum_slot;
  logic [AW-1:0] raddr;
  logic          we;
  logic          re;

  assign op = rfps_pkg::op_t'(operation);

  // Offset from the read slot, folded back into the ring. The offset is at most
  // the depth whenever the result is used, so one subtraction is enough.
  assign sum      = SW'(rd_slot) + SW'(offset);
  assign sum_slot = (sum >= SW'(DEPTH)) ? AW'(sum - SW'(DEPTH)) : AW'(sum);

  always_comb begin
    ok = 1'b0;
    case (op)
      rfps_pkg::OP_PUT:  ok = (fill < FW'(DEPTH));
      rfps_pkg::OP_TAKE: ok = (fill != '0);
      rfps_pkg::OP_PEEK: ok = (offset < fill);
      rfps_pkg::OP_SKIP: ok = (offset <= fill);
      default:           ok = 1'b0;
    endcase
  end

  assign we    = cmd.start && ok && (op == rfps_pkg::OP_PUT);
  assign re    = cmd.start && ok && ((op == rfps_pkg::OP_TAKE) || (op == rfps_pkg::OP_PEEK));
  assign raddr = (op == rfps_pkg::OP_TAKE) ? rd_slot : sum_slot;

  always_comb begin
    wr_slot_next = wr_slot;
    rd_slot_next = rd_slot;
    fill_next    = fill;
    if (cmd.start && ok) begin
      case (op)
        rfps_pkg::OP_PUT: begin
          wr_slot_next = (wr_slot == AW'(DEPTH - 1)) ? '0 : wr_slot + 1'b1;
          fill_next    = fill + 1'b1;
        end
        rfps_pkg::OP_TAKE: begin
          rd_slot_next = (rd_slot == AW'(DEPTH - 1)) ? '0 : rd_slot + 1'b1;
          fill_next    = fill - 1'b1;
        end
        rfps_pkg::OP_SKIP: begin
          rd_slot_next = sum_slot;
          fill_next    = fill - offset;
        end
        default: begin
          fill_next = fill;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_slot <= '0;
      rd_slot <= '0;
      fill    <= '0;
    end else begin
      wr_slot <= wr_slot_next;
      rd_slot <= rd_slot_next;
      fill    <= fill_next;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_slot] <= write_data;
    end
    if (re) begin
      mem_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      ok_q   <= ok;
      rd_sel <= re;
      eot_q  <= end_of_transfer;
    end
    // No word is accepted between start and load, so fill is this word's level.
    if (cmd.load) begin
      read_data  <= rd_sel ? mem_q : '0;
      success    <= ok_q;
      fill_level <= fill;
      last       <= eot_q;
    end
  end

endmodule

// File: hdl/rfps_ctrl.sv
// ----------------------------------------------------------------------------
// rfps_ctrl
// Handshake controller: one word in flight, output register valid flag.
// ----------------------------------------------------------------------------
module rfps_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  output logic           out_valid,
  input  logic           out_ready,
  output rfps_pkg::cmd_t cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_RESP
  } state_t;

  state_t state;

  assign in_ready  = (state == ST_IDLE);
  assign cmd.start = in_valid && in_ready;
  assign cmd.load  = (state == ST_RESP) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.start) begin
            state <= ST_RESP;
          end
        end
        ST_RESP: begin
          if (cmd.load) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
      if (cmd.load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// File: hdl/rfps_checker.sv
// ----------------------------------------------------------------------------
// rfps_checker
// Port-level checks for the ring buffer, bound to the top level.
// ----------------------------------------------------------------------------
module rfps_checker #(
  parameter int DEPTH      = rfps_pkg::DEPTH_DEFAULT,
  parameter int DATA_WIDTH = rfps_pkg::DATA_WIDTH_DEFAULT,
  parameter int FW         = $clog2(DEPTH + 1)
) (
  input logic                  clk,
  input logic                  rst,
  input logic                  in_valid,
  input logic                  in_ready,
  input logic                  out_valid,
  input logic                  out_ready,
  input logic [DATA_WIDTH-1:0] read_data,
  input logic [FW-1:0]         fill_level
);

  // Only one word is in flight, so acceptance drops ready in the cycle after it.
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted while a word is still in flight");

  a_no_valid_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (fill_level <= FW'(DEPTH)))
    else $error("fill level above buffer depth");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(read_data))
    else $error("stalled result word changed");

endmodule

bind ring_fifo_peek_skip rfps_checker #(
  .DEPTH      (DEPTH),
  .DATA_WIDTH (DATA_WIDTH),
  .FW         (FW)
) u_rfps_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_ready   (in_ready),
  .out_valid  (out_valid),
  .out_ready  (out_ready),
  .read_data  (read_data),
  .fill_level (fill_level)
);

// File: dv/ring_fifo_peek_skip_tb.sv
// ----------------------------------------------------------------------------
// ring_fifo_peek_skip_tb
// Self-checking bench for the ring buffer with put, take, peek and skip.
// ----------------------------------------------------------------------------
// A table of directed words runs first: empty-buffer refusals, the boundary
// offsets, a fill up to the full mark that wraps the slot index, a refused
// put, a full skip and a short second fill. Random episodes follow, weighted
// toward filling, draining or an even mix, with peek and skip offsets mostly
// inside the fill level. The shadow ring predicts the untyped rows and random
// words, while typed rows carry their own expected result; a monitor compares
// each result with the oldest prediction field by field. Both sides insert
// random gaps, and the sender waits for a full drain now and then.
// ----------------------------------------------------------------------------
module ring_fifo_peek_skip_tb;

  localparam int DEPTH = rfps_pkg::DEPTH_DEFAULT;
  localparam int DW    = rfps_pkg::DATA_WIDTH_DEFAULT;
  localparam int FW    = $clog2(DEPTH + 1);
  localparam int RANDOM_WORDS = 300;

  typedef struct packed {
    logic [DW-1:0] data;
    logic          ok;
    logic [FW-1:0] fill;
    logic          last;
  } outcome_t;

  typedef struct {
    rfps_pkg::op_t op;
    logic [DW-1:0] wd;
    logic [FW-1:0] off;
    logic          eot;
    int            reps;
    bit            typed;
    outcome_t      want;
  } plan_row_t;

  logic          clk;
  logic          rst;
  logic          in_valid;
  logic          in_ready;
  logic [1:0]    operation;
  logic [DW-1:0] write_data;
  logic [FW-1:0] offset;
  logic          end_of_transfer;
  logic          out_valid;
  logic          out_ready;
  logic [DW-1:0] read_data;
  logic          success;
  logic [FW-1:0] fill_level;
  logic          last;

  // Shadow copy of the ring: element store and the two free-running counters.
  logic [DW-1:0] shadow_mem [DEPTH];
  int            shadow_rd;
  int            shadow_wr;

  outcome_t      pending_outcomes [$];
  plan_row_t     plan [$];
  int            errors;
  bit            calm;

  ring_fifo_peek_skip DUT (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .operation       (operation),
    .write_data      (write_data),
    .offset          (offset),
    .end_of_transfer (end_of_transfer),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .read_data       (read_data),
    .success         (success),
    .fill_level      (fill_level),
    .last            (last)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic int ring_fill();
    return (shadow_wr + 2 * DEPTH - shadow_rd) % (2 * DEPTH);
  endfunction

  // Applies one word to the shadow ring and returns the result it yields.
  function automatic outcome_t ring_outcome(rfps_pkg::op_t op, logic [DW-1:0] wd, int off,
                                            logic eot);
    outcome_t r;
    int       fill;
    fill   = ring_fill();
    r      = '0;
    r.last = eot;
    case (op)
      rfps_pkg::OP_PUT: begin
        if (fill < DEPTH) begin
          shadow_mem[shadow_wr % DEPTH] = wd;
          shadow_wr = (shadow_wr + 1) % (2 * DEPTH);
          r.ok = 1'b1;
        end
      end
      rfps_pkg::OP_TAKE: begin
        if (fill > 0) begin
          r.data = shadow_mem[shadow_rd % DEPTH];
          shadow_rd = (shadow_rd + 1) % (2 * DEPTH);
          r.ok = 1'b1;
        end
      end
      rfps_pkg::OP_PEEK: begin
        if (off < fill) begin
          r.data = shadow_mem[(shadow_rd + off) % DEPTH];
          r.ok = 1'b1;
        end
      end
      default: begin
        if (off <= fill) begin
          shadow_rd = (shadow_rd + off) % (2 * DEPTH);
          r.ok = 1'b1;
        end
      end
    endcase
    r.fill = FW'(ring_fill());
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Peek and skip offsets stay mostly inside the fill level, with the exact
  // boundary and the buffer depth mixed in.
  function automatic logic [FW-1:0] pick_offset(rfps_pkg::op_t op);
    int fill;
    int r;
    fill = ring_fill();
    r    = $urandom_range(0, 99);
    if (op == rfps_pkg::OP_PEEK) begin
      if (r < 75 && fill > 0) return FW'($urandom_range(0, fill - 1));
      if (r < 85) return FW'(fill);
      if (r < 92) return FW'(DEPTH);
    end else if (op == rfps_pkg::OP_SKIP) begin
      if (r < 40) return FW'($urandom_range(0, fill < 8 ? fill : 8));
      if (r < 70) return FW'($urandom_range(0, fill));
      if (r < 80) return FW'(fill);
      if (r < 88) return FW'(fill < DEPTH ? fill + 1 : DEPTH);
    end
    return FW'($urandom_range(0, DEPTH));
  endfunction

  function automatic void add_row(rfps_pkg::op_t op, logic [DW-1:0] wd, int off, logic eot,
                                  int reps, bit typed, logic [DW-1:0] x_data, logic x_ok,
                                  int x_fill);
    plan_row_t row;
    row.op    = op;
    row.wd    = wd;
    row.off   = FW'(off);
    row.eot   = eot;
    row.reps  = reps;
    row.typed = typed;
    row.want  = '{data: x_data, ok: x_ok, fill: FW'(x_fill), last: eot};
    plan.push_back(row);
  endfunction

  // Presents one word, waits for it to be taken and records its prediction.
  task automatic send_word(rfps_pkg::op_t op, logic [DW-1:0] wd, logic [FW-1:0] off,
                           logic eot, bit typed, outcome_t want);
    int       gap;
    outcome_t res;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    operation       <= op;
    write_data      <= wd;
    offset          <= off;
    end_of_transfer <= eot;
    do @(posedge clk); while (!in_ready);
    res = ring_outcome(op, wd, int'(off), eot);
    pending_outcomes.push_back(typed ? want : res);
  endtask

  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_outcomes.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_outcomes.size() == 0) begin
        $error("result word with no prediction pending: data %0d ok %0d fill %0d",
               read_data, success, fill_level);
        errors++;
      end else begin
        want = pending_outcomes.pop_front();
        if (read_data !== want.data) begin
          $error("read_data: expected %0d, got %0d", want.data, read_data);
          errors++;
        end
        if (success !== want.ok) begin
          $error("success: expected %0d, got %0d", want.ok, success);
          errors++;
        end
        if (fill_level !== want.fill) begin
          $error("fill_level: expected %0d, got %0d", want.fill, fill_level);
          errors++;
        end
        if (last !== want.last) begin
          $error("last: expected %0d, got %0d", want.last, last);
          errors++;
        end
      end
    end
  end

  initial begin
    int gap;
    out_ready <= 1'b0;
    @(negedge rst);
    forever begin
      gap = pick_gap();
      if (gap > 0) begin
        out_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      out_ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    #8000000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int            sent;
    int            mode;
    int            len;
    int            r;
    int            put_lim;
    int            take_lim;
    int            peek_lim;
    rfps_pkg::op_t op;
    logic [DW-1:0] wd;
    rst             <= 1'b1;
    in_valid        <= 1'b0;
    operation       <= rfps_pkg::OP_PUT;
    write_data      <= '0;
    offset          <= '0;
    end_of_transfer <= 1'b0;
    errors    = 0;
    calm      = 1'b0;
    shadow_rd = 0;
    shadow_wr = 0;

    // Rows with a repeat count above one are bulk puts with random data.
    add_row(rfps_pkg::OP_TAKE, 8'h00,    0, 1'b1,    1, 1'b1, 8'h00, 1'b0,    0);
    add_row(rfps_pkg::OP_PEEK, 8'h00,    0, 1'b0,    1, 1'b1, 8'h00, 1'b0,    0);
    add_row(rfps_pkg::OP_SKIP, 8'h00,    0, 1'b1,    1, 1'b1, 8'h00, 1'b1,    0);
    add_row(rfps_pkg::OP_SKIP, 8'hff, 1024, 1'b0,    1, 1'b1, 8'h00, 1'b0,    0);
    add_row(rfps_pkg::OP_PUT,  8'hff,    0, 1'b0,    1, 1'b1, 8'h00, 1'b1,    1);
    add_row(rfps_pkg::OP_PUT,  8'h00, 1024, 1'b1,    1, 1'b1, 8'h00, 1'b1,    2);
    add_row(rfps_pkg::OP_PEEK, 8'h00,    0, 1'b0,    1, 1'b1, 8'hff, 1'b1,    2);
    add_row(rfps_pkg::OP_PEEK, 8'h00,    1, 1'b1,    1, 1'b1, 8'h00, 1'b1,    2);
    add_row(rfps_pkg::OP_PEEK, 8'h00,    2, 1'b0,    1, 1'b1, 8'h00, 1'b0,    2);
    add_row(rfps_pkg::OP_PEEK, 8'h00, 1024, 1'b1,    1, 1'b1, 8'h00, 1'b0,    2);
    add_row(rfps_pkg::OP_SKIP, 8'h00,    3, 1'b0,    1, 1'b1, 8'h00, 1'b0,    2);
    add_row(rfps_pkg::OP_TAKE, 8'h00,    0, 1'b1,    1, 1'b1, 8'hff, 1'b1,    1);
    add_row(rfps_pkg::OP_SKIP, 8'h00,    1, 1'b0,    1, 1'b1, 8'h00, 1'b1,    0);
    // The full fill starts two slots in, so the write slot wraps past the end.
    add_row(rfps_pkg::OP_PUT,  8'h00,    0, 1'b0, 1024, 1'b0, 8'h00, 1'b0,    0);
    add_row(rfps_pkg::OP_PUT,  8'ha5,    0, 1'b1,    1, 1'b1, 8'h00, 1'b0, 1024);
    add_row(rfps_pkg::OP_PEEK, 8'h00, 1023, 1'b0,    1, 1'b0, 8'h00, 1'b0,    0);
    add_row(rfps_pkg::OP_PEEK, 8'h00, 1024, 1'b1,    1, 1'b1, 8'h00, 1'b0, 1024);
    add_row(rfps_pkg::OP_SKIP, 8'h00, 1024, 1'b1,    1, 1'b1, 8'h00, 1'b1,    0);
    add_row(rfps_pkg::OP_PUT,  8'h00,    0, 1'b1,   10, 1'b0, 8'h00, 1'b0,    0);
    add_row(rfps_pkg::OP_TAKE, 8'h00,    0, 1'b0,    1, 1'b0, 8'h00, 1'b0,    0);
    add_row(rfps_pkg::OP_PEEK, 8'h00,    8, 1'b1,    1, 1'b0, 8'h00, 1'b0,    0);
    add_row(rfps_pkg::OP_SKIP, 8'h00,    0, 1'b0,    1, 1'b1, 8'h00, 1'b1,    9);

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[i]) begin
      for (int k = 0; k < plan[i].reps; k++) begin
        wd = (plan[i].reps > 1) ? DW'($urandom_range(0, 255)) : plan[i].wd;
        send_word(plan[i].op, wd, plan[i].off, plan[i].eot, plan[i].typed, plan[i].want);
      end
    end
    hold_until_drained();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      mode = $urandom_range(0, 2);
      len  = $urandom_range(10, 150);
      calm = ($urandom_range(0, 5) == 0);
      if ($urandom_range(0, 9) == 0) hold_until_drained();
      for (int k = 0; k < len && sent < RANDOM_WORDS; k++) begin
        r = $urandom_range(0, 99);
        // Mode 0 mixes evenly, mode 1 mostly fills, mode 2 mostly drains.
        case (mode)
          0: begin
            put_lim  = 35;
            take_lim = 60;
            peek_lim = 80;
          end
          1: begin
            put_lim  = 80;
            take_lim = 87;
            peek_lim = 94;
          end
          default: begin
            put_lim  = 10;
            take_lim = 50;
            peek_lim = 75;
          end
        endcase
        if (r < put_lim) op = rfps_pkg::OP_PUT;
        else if (r < take_lim) op = rfps_pkg::OP_TAKE;
        else if (r < peek_lim) op = rfps_pkg::OP_PEEK;
        else op = rfps_pkg::OP_SKIP;
        send_word(op, DW'($urandom_range(0, 255)), pick_offset(op),
                  1'($urandom_range(0, 1)), 1'b0, '0);
        sent++;
      end
    end
    calm = 1'b0;

    in_valid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// File: filelist.f
hdl/rfps_pkg.sv
hdl/rfps_datapath.sv
hdl/rfps_ctrl.sv
hdl/ring_fifo_peek_skip.sv
hdl/rfps_checker.sv
dv/ring_fifo_peek_skip_tb.sv
